FILE: design/pgu_pkg.sv
// Shared types, codes and helpers for the packed text glyph unpacker.
// No dependencies; imported by the result queue and the top level.
package pgu_pkg;

	localparam int GLYPH_ENTRIES_DEF = 64;
	localparam int CODE_W            = 5;
	localparam int IDX_W_MAX         = 6;
	localparam int WORD_W            = 16;
	localparam int OFFS_W            = 8;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

	// Request kinds on the input channel
	typedef enum logic [1:0] {
		ACT_TEXT  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_START = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// One result as delivered on the output channel
	typedef struct packed {
		logic              glyph_valid;
		logic [WORD_W-1:0] glyph_word;
		logic [OFFS_W-1:0] list_offset;
		logic              last;
		logic [OFFS_W-1:0] bytes_written;
	} result_t;

	// One pending result before its table read
	typedef struct packed {
		logic                 is_glyph;
		logic [IDX_W_MAX-1:0] idx;
		logic [OFFS_W-1:0]    offset;
		logic                 last;
		logic [OFFS_W-1:0]    bytes;
	} desc_t;

	// Codes 1..4 map to entries 0..3, codes 5..31 to entries 11..37
	function automatic logic [IDX_W_MAX-1:0] glyph_index(input logic [CODE_W-1:0] code);
		logic [IDX_W_MAX-1:0] c6;
		c6 = {1'b0, code};
		if (code < 5'd5) begin
			return c6 - 6'd1;
		end
		return c6 + 6'd6;
	endfunction

	function automatic desc_t mk_glyph(input logic [CODE_W-1:0] code,
	                                   input logic [OFFS_W-1:0] at,
	                                   input logic              is_last,
	                                   input logic [OFFS_W-1:0] after);
		desc_t d;
		d.is_glyph = 1'b1;
		d.idx      = glyph_index(code);
		d.offset   = at;
		d.last     = is_last;
		d.bytes    = is_last ? after : '0;
		return d;
	endfunction

	function automatic desc_t mk_end(input logic [OFFS_W-1:0] written);
		desc_t d;
		d.is_glyph = 1'b0;
		d.idx      = '0;
		d.offset   = '0;
		d.last     = 1'b1;
		d.bytes    = written;
		return d;
	endfunction

endpackage

FILE: design/pgu_result_fifo.sv
// Result queue between the table read stage and the output channel.
// Depends on pgu_pkg (result_t, FIFO_DEPTH).
module pgu_result_fifo
	import pgu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               push_data,
	input  logic                  pop_stall,
	output logic                  head_valid,
	output result_t               head_data,
	output logic [FIFO_CNT_W-1:0] count
);

	result_t               entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = count_q;
	assign pop        = head_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/packed_text_glyph_unpacker.sv
// Top level of the packed text glyph unpacker: decode, glyph table RAM, read stage.
// Depends on pgu_pkg and pgu_result_fifo.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_stall  | action, packed_byte, load_index, load_word
//   out     | out_valid/out_stall| glyph_valid, glyph_word, list_offset, last,
//           |                    | bytes_written
//
// Rate: one request per cycle unless the input is stalled; a second text byte that
// yields two results holds the input while its second result waits, since the
// glyph table has a single read port.
// Path: the first result of a request passes through the read stage register into
// the queue; a second result waits in the pending register before the read stage.
// Reset clears the pair phase, offset, end flag and queue; the table is kept
// undefined until loaded. A stalled output backs up the 4-entry queue; the input
// stalls while a second result waits for the read port, and while the queue plus
// the read stage hold four results.
module packed_text_glyph_unpacker
	import pgu_pkg::*;
#(
	parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic [7:0]           packed_byte,
	input  logic [IDX_W_MAX-1:0] load_index,
	input  logic [WORD_W-1:0]    load_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 glyph_valid,
	output logic [WORD_W-1:0]    glyph_word,
	output logic [OFFS_W-1:0]    list_offset,
	output logic                 last,
	output logic [OFFS_W-1:0]    bytes_written
);

	localparam int ADDR_W = $clog2(GLYPH_ENTRIES);
	// entry count held one bit wider so a full 64-entry table still compares
	localparam logic [IDX_W_MAX:0] ENTRIES = (IDX_W_MAX + 1)'(GLYPH_ENTRIES);

	// message state
	logic              sbn_q;        // second byte of a pair expected next
	logic [2:0]        held_q;       // low bits of the first byte
	logic [OFFS_W-1:0] off_q;        // running display list offset
	logic              done_q;       // message ended, ignore text

	// second result of a byte pair, waiting for the read port
	logic  pend_valid_q;
	desc_t pend_q;

	// read stage
	logic              valid_s1;
	desc_t             desc_s1;
	logic [WORD_W-1:0] rdata_s1;

	logic [WORD_W-1:0] glyph_mem [GLYPH_ENTRIES];

	// decode outputs
	desc_t             da, db;
	logic              a_vld, b_vld;
	logic              nxt_sbn, nxt_done;
	logic [2:0]        nxt_held;
	logic [OFFS_W-1:0] nxt_off;
	logic [CODE_W-1:0] code1, code2;
	logic [OFFS_W-1:0] off2, off4;

	logic              accept, is_text, occ_full;
	logic [FIFO_CNT_W:0] occ;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic              iss_valid;
	desc_t             iss_desc;
	result_t           push_data, head;

	assign accept  = in_valid && !in_stall;
	assign is_text = (action_t'(action) == ACT_TEXT) && !done_q;
	assign off2    = off_q + 8'd2;
	assign off4    = off_q + 8'd4;

	// Split the byte into codes; at most two results per request.
	always_comb begin
		da       = mk_end(off_q);
		db       = mk_end(off2);
		a_vld    = 1'b0;
		b_vld    = 1'b0;
		nxt_sbn  = sbn_q;
		nxt_held = held_q;
		nxt_off  = off_q;
		nxt_done = done_q;
		code1    = packed_byte[7:3];
		code2    = packed_byte[5:1];
		if (is_text) begin
			a_vld = 1'b1;
			if (!sbn_q) begin
				if (code1 == '0) begin
					nxt_done = 1'b1;
				end else begin
					da       = mk_glyph(code1, off_q, 1'b0, off2);
					nxt_off  = off2;
					nxt_held = packed_byte[2:0];
					nxt_sbn  = 1'b1;
				end
			end else begin
				nxt_sbn = 1'b0;
				code1   = {held_q, packed_byte[7:6]};
				if (code1 == '0) begin
					nxt_done = 1'b1;
				end else begin
					da    = mk_glyph(code1, off_q, 1'b0, off2);
					b_vld = 1'b1;
					if (code2 == '0) begin
						// end marker right after the middle glyph
						db       = mk_end(off2);
						nxt_off  = off2;
						nxt_done = 1'b1;
					end else begin
						db       = mk_glyph(code2, off2, packed_byte[0], off4);
						nxt_off  = off4;
						nxt_done = packed_byte[0];
					end
				end
			end
		end
	end

	// Credit check: queue entries plus the one in the read stage
	assign occ      = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, valid_s1};
	assign occ_full = (occ >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	// Pending second result owns the read port; hold off loads behind it too.
	assign in_stall = pend_valid_q || occ_full;

	always_comb begin
		iss_valid = 1'b0;
		iss_desc  = da;
		if (pend_valid_q && !occ_full) begin
			iss_valid = 1'b1;
			iss_desc  = pend_q;
		end else if (accept && a_vld) begin
			iss_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbn_q        <= 1'b0;
			held_q       <= '0;
			off_q        <= '0;
			done_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= iss_valid;
			if (pend_valid_q && !occ_full) begin
				pend_valid_q <= 1'b0;
			end else if (accept && b_vld) begin
				pend_valid_q <= 1'b1;
			end
			if (accept) begin
				case (action_t'(action))
					ACT_START: begin
						sbn_q  <= 1'b0;
						held_q <= '0;
						off_q  <= '0;
						done_q <= 1'b0;
					end
					ACT_TEXT: begin
						sbn_q  <= nxt_sbn;
						held_q <= nxt_held;
						off_q  <= nxt_off;
						done_q <= nxt_done;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && b_vld) begin
			pend_q <= db;
		end
		if (iss_valid) begin
			desc_s1 <= iss_desc;
		end
	end

	// Glyph table: one write port for loads, one registered read port.
	// Read sees the old word when a load hits the same entry in that cycle.
	always_ff @(posedge clk) begin
		if (accept && (action_t'(action) == ACT_LOAD) && ({1'b0, load_index} < ENTRIES)) begin
			glyph_mem[load_index[ADDR_W-1:0]] <= load_word;
		end
		if (iss_valid && iss_desc.is_glyph && ({1'b0, iss_desc.idx} < ENTRIES)) begin
			rdata_s1 <= glyph_mem[iss_desc.idx[ADDR_W-1:0]];
		end
	end

	always_comb begin
		push_data.glyph_valid   = desc_s1.is_glyph;
		push_data.glyph_word    = (desc_s1.is_glyph && ({1'b0, desc_s1.idx} < ENTRIES))
		                          ? rdata_s1 : '0;
		push_data.list_offset   = desc_s1.offset;
		push_data.last          = desc_s1.last;
		push_data.bytes_written = desc_s1.bytes;
	end

	pgu_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (valid_s1),
		.push_data  (push_data),
		.pop_stall  (out_stall),
		.head_valid (out_valid),
		.head_data  (head),
		.count      (fifo_count)
	);

	assign glyph_valid   = head.glyph_valid;
	assign glyph_word    = head.glyph_word;
	assign list_offset   = head.list_offset;
	assign last          = head.last;
	assign bytes_written = head.bytes_written;

endmodule

FILE: design/pgu_checker.sv
// Port-level checks for packed_text_glyph_unpacker, attached by bind.
// Depends only on the top level's ports.
module pgu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        glyph_valid,
	input logic [15:0] glyph_word,
	input logic [7:0]  list_offset,
	input logic        last,
	input logic [7:0]  bytes_written
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(glyph_valid) && $stable(glyph_word)
			&& $stable(list_offset) && $stable(last) && $stable(bytes_written))
		else $error("stalled result changed");

	// an end marker carries no glyph and always closes the message
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !glyph_valid |-> last && (glyph_word == 16'd0) && (list_offset == 8'd0))
		else $error("bad end marker");

	// byte count only on the closing result
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> glyph_valid && (bytes_written == 8'd0))
		else $error("byte count outside the closing result");

	// a closing glyph accounts for its own two bytes
	a_last_glyph_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_valid && last |-> bytes_written == 8'(list_offset + 8'd2))
		else $error("closing glyph byte count mismatch");

endmodule

bind packed_text_glyph_unpacker pgu_checker u_pgu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.glyph_valid   (glyph_valid),
	.glyph_word    (glyph_word),
	.list_offset   (list_offset),
	.last          (last),
	.bytes_written (bytes_written)
);
